// ===== rtl/core/sitoa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_pkg: shared types and constants
// Types and constants for the signed 64-bit integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  // Operand and BCD geometry
  localparam int MAG_W    = 64;
  localparam int DIGITS   = 20;
  localparam int DIGIT_W  = 4;
  localparam int BCD_W    = DIGITS * DIGIT_W;
  localparam int CNT_W    = $clog2(MAG_W);
  localparam int IDX_W    = $clog2(DIGITS);
  localparam int CHAR_W   = 8;

  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(MAG_W - 1);
  localparam logic [IDX_W-1:0] DIGIT_LAST = IDX_W'(DIGITS - 1);

  // ASCII codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // Double-dabble correction for radix 10
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

  // Classified request passed from front to back
  typedef struct packed {
    logic             negative;
    logic [MAG_W-1:0] mag;
  } sitoa_item_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } sitoa_state_t;

  // Digit correction before each shift
  function automatic logic [DIGIT_W-1:0] bcd_adjust(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= BCD_ADJ_MIN) ? (d + BCD_ADJ_ADD) : d;
    return r;
  endfunction

endpackage

// ===== rtl/core/sitoa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_front: request intake
// Accepts a signed value, splits it into sign and unsigned magnitude and
// pushes the classified request into the queue.
// ----------------------------------------------------------------------------
module sitoa_front (
  input  logic                       start,
  output logic                       busy,
  input  logic signed [63:0]         value,
  input  logic                       q_full,
  output logic                       q_push,
  output sitoa_pkg::sitoa_item_t     q_item
);

  logic [63:0] raw;

  // Sign and magnitude; the most negative value maps to 2^63 unsigned
  always_comb begin
    raw             = value;
    q_item.negative = raw[63];
    q_item.mag      = raw[63] ? (~raw + 64'd1) : raw;
  end

  assign busy   = q_full;
  assign q_push = start && !q_full;

endmodule

// ===== rtl/core/sitoa_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_queue: request queue
// Small FIFO between the intake and the converter.
// ----------------------------------------------------------------------------
module sitoa_queue #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sitoa_pkg::sitoa_item_t push_item,
  output logic                   full,
  input  logic                   pop,
  output sitoa_pkg::sitoa_item_t head,
  output logic                   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sitoa_pkg::sitoa_item_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/sitoa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_back: bit-serial converter and character emitter
// Double-dabble conversion, then an optional sign and one digit slot per
// cycle, leading zeros suppressed.
// ----------------------------------------------------------------------------
module sitoa_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  sitoa_pkg::sitoa_item_t q_head,
  output logic                   q_pop,
  output logic                   strobe,
  output logic [7:0]             character,
  output logic                   last
);

  sitoa_pkg::sitoa_state_t state;
  sitoa_pkg::sitoa_state_t state_next;

  logic [sitoa_pkg::MAG_W-1:0]   bin;
  logic [sitoa_pkg::BCD_W-1:0]   bcd;
  logic [sitoa_pkg::BCD_W-1:0]   bcd_adj;
  logic                          negative;
  logic [sitoa_pkg::CNT_W-1:0]   cnt;
  logic [sitoa_pkg::IDX_W-1:0]   idx;
  logic                          started;
  logic [sitoa_pkg::DIGIT_W-1:0] top_digit;

  logic       emit_valid;
  logic [7:0] emit_char;
  logic       emit_last;

  assign top_digit = bcd[sitoa_pkg::BCD_W-1 -: sitoa_pkg::DIGIT_W];

  // Per-digit correction ahead of the shift
  always_comb begin
    for (int i = 0; i < sitoa_pkg::DIGITS; i++) begin
      bcd_adj[i*sitoa_pkg::DIGIT_W +: sitoa_pkg::DIGIT_W] =
        sitoa_pkg::bcd_adjust(bcd[i*sitoa_pkg::DIGIT_W +: sitoa_pkg::DIGIT_W]);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sitoa_pkg::ST_IDLE: begin
        if (!q_empty) state_next = sitoa_pkg::ST_CONV;
      end
      sitoa_pkg::ST_CONV: begin
        if (cnt == sitoa_pkg::CNT_LAST) begin
          state_next = negative ? sitoa_pkg::ST_SIGN : sitoa_pkg::ST_EMIT;
        end
      end
      sitoa_pkg::ST_SIGN: begin
        state_next = sitoa_pkg::ST_EMIT;
      end
      sitoa_pkg::ST_EMIT: begin
        if (idx == sitoa_pkg::DIGIT_LAST) state_next = sitoa_pkg::ST_IDLE;
      end
      default: begin
        state_next = sitoa_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    q_pop      = 1'b0;
    emit_valid = 1'b0;
    emit_char  = sitoa_pkg::ASCII_ZERO;
    emit_last  = 1'b0;
    case (state)
      sitoa_pkg::ST_IDLE: begin
        q_pop = !q_empty;
      end
      sitoa_pkg::ST_SIGN: begin
        emit_valid = 1'b1;
        emit_char  = sitoa_pkg::ASCII_MINUS;
      end
      sitoa_pkg::ST_EMIT: begin
        // Units digit always shows, so zero prints as '0'
        emit_valid = started || (top_digit != '0) || (idx == sitoa_pkg::DIGIT_LAST);
        emit_char  = sitoa_pkg::ASCII_ZERO + {4'd0, top_digit};
        emit_last  = (idx == sitoa_pkg::DIGIT_LAST);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // State register and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= sitoa_pkg::ST_IDLE;
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit_valid;
      last   <= emit_valid && emit_last;
    end
  end

  // Result character
  always_ff @(posedge clk) begin
    character <= emit_char;
  end

  // Conversion datapath
  always_ff @(posedge clk) begin
    case (state)
      sitoa_pkg::ST_IDLE: begin
        bin      <= q_head.mag;
        negative <= q_head.negative;
        bcd      <= '0;
        cnt      <= '0;
        idx      <= '0;
        started  <= 1'b0;
      end
      sitoa_pkg::ST_CONV: begin
        bcd <= {bcd_adj[sitoa_pkg::BCD_W-2:0], bin[sitoa_pkg::MAG_W-1]};
        bin <= {bin[sitoa_pkg::MAG_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      sitoa_pkg::ST_EMIT: begin
        bcd     <= {bcd[sitoa_pkg::BCD_W-sitoa_pkg::DIGIT_W-1:0],
                    {sitoa_pkg::DIGIT_W{1'b0}}};
        idx     <= idx + 1'b1;
        started <= started || (top_digit != '0);
      end
      default: begin
        bin <= bin;
      end
    endcase
  end

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii_top.sv =====
`timescale 1ns / 1ps
// With an idle converter the sign or first digit shows after the load and the
//   shift steps, later for short values as leading zeros are suppressed.
// Per value the converter runs a load step, 64 double-dabble shift steps, one
//   sign slot if negative and 20 digit slots, and takes no new value until done.
// The request queue accepts up to QUEUE_DEPTH values ahead of the converter.
// Reset is synchronous and empties the queue and returns the converter to idle.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top: signed integer to decimal text
// Intake, request queue and bit-serial converter emitting one ASCII character
// per strobe, last marking the end of each value's text.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [63:0] value,
  output logic               strobe,
  output logic [7:0]         character,
  output logic               last
);

  sitoa_pkg::sitoa_item_t push_item;
  sitoa_pkg::sitoa_item_t head;
  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;

  sitoa_front u_front (
    .start  (start),
    .busy   (busy),
    .value  (value),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (push_item)
  );

  sitoa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty)
  );

  sitoa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (head),
    .q_pop     (q_pop),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

endmodule

// ===== rtl/core/sitoa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitoa_checker: port-level checks
// Watches the converter's ports for malformed character output.
// ----------------------------------------------------------------------------
module sitoa_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       strobe,
  input logic [7:0] character,
  input logic       last
);

  // End marker only rides on a delivered character
  a_last_needs_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> strobe)
    else $error("last without strobe");

  // Only a minus sign or a decimal digit is ever produced
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (character == sitoa_pkg::ASCII_MINUS) ||
               ((character >= sitoa_pkg::ASCII_ZERO) &&
                (character <= sitoa_pkg::ASCII_ZERO + 8'd9)))
    else $error("illegal character");

  // A sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (character == sitoa_pkg::ASCII_MINUS)) |-> !last)
    else $error("sign marked last");

  // Reset leaves nothing pending and the intake open
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!strobe && !busy))
    else $error("output or busy after reset");

endmodule

bind signed_int_to_decimal_ascii_top sitoa_checker u_sitoa_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .strobe    (strobe),
  .character (character),
  .last      (last)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: signed 64-bit integer to decimal ASCII converter testbench
// Drives signed values through the start/busy intake and checks every
// strobed character and last flag against typed-in or locally predicted text.
// A directed table covers zero, the sign, digit-count boundaries and both
// extremes; random values with random idle gaps follow.
// ----------------------------------------------------------------------------
module tb;

  localparam int DIR_N      = 22;
  localparam int RAND_N     = 250;
  localparam int CYCLE_MAX  = 200000;
  localparam int DRAIN_WAIT = 120;

  typedef struct {
    logic [7:0] ch;
    logic       lst;
  } text_char_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic signed [63:0] value;
  logic               busy;
  logic               strobe;
  logic [7:0]         character;
  logic               last;

  text_char_t text_q[$];
  int         err_count;
  int         char_count;
  int         value_count;
  int         neg_count;
  int         cycle_count;
  logic       burst_mode;

  // Directed values and their text where it is obvious; empty means predict
  logic [63:0] dir_val[DIR_N] = '{
    64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99, 64'd100,
    -64'sd100, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE, 64'd1000000000000000000,
    64'd999999999999999999, -64'sd1000000000000000000, 64'd12345,
    -64'sd987654321, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
    64'h0000_0000_FFFF_FFFF
  };
  string dir_txt[DIR_N] = '{
    "0", "1", "-1", "9", "-9", "10", "-10", "99", "100", "-100",
    "9223372036854775807", "-9223372036854775808", "-9223372036854775807",
    "9223372036854775806", "1000000000000000000", "999999999999999999",
    "-1000000000000000000", "", "", "", "", ""
  };

  signed_int_to_decimal_ascii_top uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 64'd10;
    return p;
  endfunction

  // Expected decimal text of one value: sign, then digits MSD first
  task automatic predict_text(input logic [63:0] v);
    logic        neg;
    logic [63:0] mag;
    logic [3:0]  digs[20];
    int          nd;
    text_char_t  tc;
    neg = v[63];
    mag = neg ? (~v + 64'd1) : v;
    nd  = 0;
    do begin
      digs[nd] = 4'(mag % 64'd10);
      mag      = mag / 64'd10;
      nd++;
    end while (mag != 64'd0 && nd < 20);
    if (neg) begin
      tc.ch  = sitoa_pkg::ASCII_MINUS;
      tc.lst = 1'b0;
      text_q.push_back(tc);
      neg_count++;
    end
    for (int k = nd - 1; k >= 0; k--) begin
      tc.ch  = sitoa_pkg::ASCII_ZERO + 8'(digs[k]);
      tc.lst = (k == 0);
      text_q.push_back(tc);
    end
  endtask

  // Expected text typed in directly
  task automatic push_text(input string s);
    text_char_t tc;
    for (int i = 0; i < s.len(); i++) begin
      tc.ch  = s[i];
      tc.lst = (i == s.len() - 1);
      text_q.push_back(tc);
    end
    if (s[0] == "-") neg_count++;
  endtask

  // Mostly digit-count-shaped values, some full-width noise and boundaries
  function automatic logic [63:0] rand_value();
    int          kind;
    int          nd;
    logic [63:0] r;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mag;
    kind = $urandom_range(0, 9);
    r    = {$urandom(), $urandom()};
    if (kind < 2) return r;
    if (kind == 2) begin
      nd  = $urandom_range(1, 18);
      mag = pow10(nd) + 64'($urandom_range(0, 2)) - 64'd1;
    end else begin
      nd  = $urandom_range(1, 19);
      lo  = (nd == 1) ? 64'd0 : pow10(nd - 1);
      hi  = (nd == 19) ? 64'h7FFF_FFFF_FFFF_FFFF : pow10(nd) - 64'd1;
      mag = lo + r % (hi - lo + 64'd1);
    end
    return $urandom_range(0, 1) ? (~mag + 64'd1) : mag;
  endfunction

  // Idle gap: none in burst stretches, else mostly short, a few long
  function automatic int pick_gap();
    int p;
    if (burst_mode) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 88) return $urandom_range(1, 4);
    return $urandom_range(10, 100);
  endfunction

  // Present one request and hold it until accepted, then idle if a gap is drawn
  task automatic send_value(input logic [63:0] v, input string txt);
    int gap;
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    if (txt.len() != 0) push_text(txt);
    else predict_text(v);
    value_count++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    text_char_t exp_c;
    if (!rst && strobe) begin
      char_count++;
      if (text_q.size() == 0) begin
        $error("unexpected character %0d last %0b", character, last);
        err_count++;
      end else begin
        exp_c = text_q.pop_front();
        if (character !== exp_c.ch) begin
          $error("character: expected %0d actual %0d", exp_c.ch, character);
          err_count++;
        end
        if (last !== exp_c.lst) begin
          $error("last: expected %0b actual %0b", exp_c.lst, last);
          err_count++;
        end
      end
    end
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_MAX) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

  // Stimulus
  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    value       = '0;
    err_count   = 0;
    char_count  = 0;
    value_count = 0;
    neg_count   = 0;
    burst_mode  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) send_value(dir_val[i], dir_txt[i]);

    for (int i = 0; i < RAND_N; i++) begin
      if (i % 16 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_value(rand_value(), "");
    end
    start <= 1'b0;

    // Drain, then watch for stray characters
    while (text_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Converted %0d values (%0d negative) into %0d characters.",
             value_count, neg_count, char_count);
    $display("Covered zero, both extremes, digit-count edges, random gaps.");
    if (err_count == 0 && text_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
